@@ rtl/fixed_block_pool_allocator_top_assert.svh @@
// assertion macros for the block pool allocator checker
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define FBPA_AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define FBPA_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fbpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, codes and helpers of the block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int CW  = 11;
    localparam int BSW = 17;
    localparam int AW  = 32;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_STATS = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXHAUSTED = 3'd1;
    localparam logic [2:0] ST_NOT_POOL  = 3'd2;
    localparam logic [2:0] ST_NULL      = 3'd3;
    localparam logic [2:0] ST_OVERFREE  = 3'd4;

    localparam logic [1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE  = 2'd1;
    localparam logic [1:0] REG_POOL_BLOCKS = 2'd2;

    localparam logic [AW-1:0]  POOL_BASE_RST   = 32'd4096;
    localparam logic [BSW-1:0] BLOCK_SIZE_RST  = 17'd8;
    localparam logic [CW-1:0]  POOL_BLOCKS_RST = 11'd1024;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_CLS
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_DIV,
        B_FIN
    } t_bstate;

    typedef struct packed {
        logic [1:0]    op;
        logic [2:0]    status;
        logic [AW-1:0] off;
    } t_cmd;

    function automatic logic [CW-1:0] eff_blocks(input logic [CW-1:0] pb,
                                                 input logic [BSW-1:0] maxb);
        logic [CW-1:0] res;
        if (pb == '0) begin
            res = 11'd1;
        end else if ({6'd0, pb} > maxb) begin
            res = maxb[CW-1:0];
        end else begin
            res = pb;
        end
        return res;
    endfunction

    function automatic logic [BSW-1:0] eff_size(input logic [BSW-1:0] bs);
        return (bs < 17'd8) ? 17'd8 : bs;
    endfunction

    function automatic logic [CW-1:0] used_of(input logic [CW-1:0] ft,
                                              input logic [CW-1:0] nb);
        return (ft >= nb) ? '0 : nb - ft;
    endfunction

endpackage

@@ rtl/fbpa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fbpa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_front
// Takes a request, works out offset and pool span, classifies frees.
// ----------------------------------------------------------------------------
module fbpa_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [1:0]               i_op,
    input  logic [fbpa_pkg::AW-1:0]  i_address,
    input  logic [fbpa_pkg::AW-1:0]  i_pool_base,
    input  logic [fbpa_pkg::BSW-1:0] i_bsize,
    input  logic [fbpa_pkg::CW-1:0]  i_nblocks,
    input  logic                     i_q_full,
    output logic                     o_push,
    output fbpa_pkg::t_cmd           o_cmd
);

    localparam int LW = fbpa_pkg::BSW + fbpa_pkg::CW;

    fbpa_pkg::t_fstate r_state, n_state;
    logic [1:0]              r_op;
    logic [fbpa_pkg::AW-1:0] r_addr;
    logic [fbpa_pkg::AW-1:0] r_off;
    logic [LW-1:0]           r_lim;
    logic                    r_below;
    logic                    r_null;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbpa_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op   <= i_op;
            r_addr <= i_address;
        end
        if (r_state == fbpa_pkg::F_CALC) begin
            r_off   <= r_addr - i_pool_base;
            r_lim   <= LW'(i_bsize) * LW'(i_nblocks);
            r_below <= r_addr < i_pool_base;
            r_null  <= r_addr == '0;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_push       = 1'b0;
        o_cmd.op     = r_op;
        o_cmd.off    = r_off;
        o_cmd.status = fbpa_pkg::ST_OK;
        if (r_op == fbpa_pkg::OP_FREE) begin
            if (r_null) begin
                o_cmd.status = fbpa_pkg::ST_NULL;
            end else if (r_below || ({1'b0, r_off} >= 33'(r_lim))) begin
                o_cmd.status = fbpa_pkg::ST_NOT_POOL;
            end
        end
        case (r_state)
            fbpa_pkg::F_IDLE: begin
                if (i_accept) n_state = fbpa_pkg::F_CALC;
            end
            fbpa_pkg::F_CALC: begin
                n_state = fbpa_pkg::F_CLS;
            end
            fbpa_pkg::F_CLS: begin
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = fbpa_pkg::F_IDLE;
                end
            end
            default: n_state = fbpa_pkg::F_IDLE;
        endcase
    end

endmodule

@@ rtl/fbpa_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_queue
// Two entry command queue between front and back.
// ----------------------------------------------------------------------------
module fbpa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fbpa_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output fbpa_pkg::t_cmd o_cmd
);

    fbpa_pkg::t_cmd r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           do_push, do_pop;

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

@@ rtl/fbpa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_back
// Executes commands on the free stack: pop, aligned push, rebuild, stats.
// ----------------------------------------------------------------------------
module fbpa_back #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  fbpa_pkg::t_cmd           i_cmd,
    output logic                     o_pop,
    input  logic [fbpa_pkg::AW-1:0]  i_pool_base,
    input  logic [fbpa_pkg::BSW-1:0] i_bsize,
    input  logic [fbpa_pkg::CW-1:0]  i_nblocks,
    output logic                     o_valid,
    output logic [2:0]               o_status,
    output logic [fbpa_pkg::AW-1:0]  o_block_address,
    output logic [fbpa_pkg::CW-1:0]  o_free_count,
    output logic [fbpa_pkg::CW-1:0]  o_used_count,
    output logic [fbpa_pkg::CW-1:0]  o_peak_usage,
    output logic [31:0]              o_total_allocations,
    output logic [31:0]              o_total_frees,
    output logic                     o_pool_empty,
    output logic                     o_pool_full
);

    localparam int IW  = $clog2(MAX_BLOCKS);
    localparam int PW  = IW + fbpa_pkg::BSW;
    localparam int RW  = (PW > fbpa_pkg::AW) ? PW : fbpa_pkg::AW;
    localparam int NW  = $clog2(IW + 1);
    localparam logic [fbpa_pkg::CW-1:0] NB_RST =
        fbpa_pkg::eff_blocks(fbpa_pkg::POOL_BLOCKS_RST, 17'(MAX_BLOCKS));

    fbpa_pkg::t_bstate r_state, n_state;
    fbpa_pkg::t_cmd    r_cmd;
    logic [2:0]        r_st;
    logic [fbpa_pkg::CW-1:0] r_free_top, n_free_top;
    logic [fbpa_pkg::CW-1:0] r_vlim, n_vlim;
    logic [fbpa_pkg::CW-1:0] r_nbr, n_nbr;
    logic [fbpa_pkg::CW-1:0] r_peak, n_peak;
    logic [31:0]       r_alloc_tot, n_alloc_tot;
    logic [31:0]       r_free_tot, n_free_tot;
    logic [PW-1:0]     r_prod;
    logic [RW-1:0]     r_rem, r_div;
    logic [IW-1:0]     r_quo;
    logic [NW-1:0]     r_cnt;
    logic [fbpa_pkg::CW-1:0] top_m1;
    logic [IW-1:0]     rdata, idx;
    logic              we;
    logic              fin;
    logic [2:0]        fin_st;
    logic [fbpa_pkg::AW-1:0] fin_blk;

    logic              r_valid;
    logic [2:0]        r_o_st;
    logic [fbpa_pkg::AW-1:0] r_o_blk;
    logic [fbpa_pkg::CW-1:0] r_o_free, r_o_used, r_o_peak;
    logic [31:0]       r_o_atot, r_o_ftot;

    assign top_m1 = r_free_top - 11'd1;

    fbpa_ram #(
        .WIDTH(IW),
        .DEPTH(MAX_BLOCKS)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(IW'(r_free_top)),
        .i_wdata(r_quo),
        .i_raddr(IW'(top_m1)),
        .o_rdata(rdata)
    );

    // entries below the low mark still hold their rebuilt value
    assign idx = (top_m1 < r_vlim) ? IW'(r_nbr - 11'd1 - top_m1) : rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fbpa_pkg::B_IDLE;
            r_free_top  <= NB_RST;
            r_vlim      <= NB_RST;
            r_nbr       <= NB_RST;
            r_peak      <= '0;
            r_alloc_tot <= '0;
            r_free_tot  <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_top  <= n_free_top;
            r_vlim      <= n_vlim;
            r_nbr       <= n_nbr;
            r_peak      <= n_peak;
            r_alloc_tot <= n_alloc_tot;
            r_free_tot  <= n_free_tot;
            r_valid     <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            if (i_cmd.op == fbpa_pkg::OP_ALLOC) begin
                r_st <= (r_free_top == '0) ? fbpa_pkg::ST_EXHAUSTED : fbpa_pkg::ST_OK;
            end else begin
                r_st <= i_cmd.status;
            end
            r_rem <= RW'(i_cmd.off);
            r_div <= RW'(i_bsize) << (IW - 1);
            r_cnt <= NW'(IW);
            r_quo <= '0;
        end
        if (r_state == fbpa_pkg::B_READ) begin
            r_prod <= PW'(idx) * PW'(i_bsize);
        end
        if (r_state == fbpa_pkg::B_DIV) begin
            if (r_rem >= r_div) begin
                r_rem <= r_rem - r_div;
                r_quo <= (r_quo << 1) | IW'(1);
            end else begin
                r_quo <= r_quo << 1;
            end
            r_div <= r_div >> 1;
            r_cnt <= r_cnt - NW'(1);
        end
        if (fin) begin
            r_o_st   <= fin_st;
            r_o_blk  <= fin_blk;
            r_o_free <= n_free_top;
            r_o_used <= fbpa_pkg::used_of(n_free_top, i_nblocks);
            r_o_peak <= n_peak;
            r_o_atot <= n_alloc_tot;
            r_o_ftot <= n_free_tot;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_free_top  = r_free_top;
        n_vlim      = r_vlim;
        n_nbr       = r_nbr;
        n_peak      = r_peak;
        n_alloc_tot = r_alloc_tot;
        n_free_tot  = r_free_tot;
        o_pop       = 1'b0;
        we          = 1'b0;
        fin         = 1'b0;
        fin_st      = r_st;
        fin_blk     = '0;
        case (r_state)
            fbpa_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.op == fbpa_pkg::OP_ALLOC && r_free_top != '0) begin
                        n_state = fbpa_pkg::B_READ;
                    end else if (i_cmd.op == fbpa_pkg::OP_FREE
                                 && i_cmd.status == fbpa_pkg::ST_OK) begin
                        n_state = fbpa_pkg::B_DIV;
                    end else begin
                        n_state = fbpa_pkg::B_FIN;
                    end
                end
            end
            fbpa_pkg::B_READ: begin
                n_state = fbpa_pkg::B_FIN;
            end
            fbpa_pkg::B_DIV: begin
                if (r_cnt == NW'(1)) n_state = fbpa_pkg::B_FIN;
            end
            fbpa_pkg::B_FIN: begin
                fin     = 1'b1;
                n_state = fbpa_pkg::B_IDLE;
                case (r_cmd.op)
                    fbpa_pkg::OP_ALLOC: begin
                        if (r_st == fbpa_pkg::ST_OK) begin
                            n_free_top  = top_m1;
                            n_alloc_tot = r_alloc_tot + 32'd1;
                            fin_blk     = i_pool_base + fbpa_pkg::AW'(r_prod);
                            if (fbpa_pkg::used_of(top_m1, i_nblocks) > r_peak) begin
                                n_peak = fbpa_pkg::used_of(top_m1, i_nblocks);
                            end
                        end
                    end
                    fbpa_pkg::OP_FREE: begin
                        if (r_st == fbpa_pkg::ST_OK) begin
                            if (r_rem != '0) begin
                                fin_st = fbpa_pkg::ST_NOT_POOL;
                            end else if (r_free_top >= i_nblocks) begin
                                fin_st = fbpa_pkg::ST_OVERFREE;
                            end else begin
                                we         = 1'b1;
                                n_free_top = r_free_top + 11'd1;
                                n_free_tot = r_free_tot + 32'd1;
                                if (r_free_top < r_vlim) n_vlim = r_free_top;
                            end
                        end
                    end
                    fbpa_pkg::OP_CLEAR: begin
                        n_free_top = i_nblocks;
                        n_vlim     = i_nblocks;
                        n_nbr      = i_nblocks;
                    end
                    default: begin
                        n_peak      = fbpa_pkg::used_of(r_free_top, i_nblocks);
                        n_alloc_tot = '0;
                        n_free_tot  = '0;
                    end
                endcase
            end
            default: n_state = fbpa_pkg::B_IDLE;
        endcase
    end

    assign o_valid             = r_valid;
    assign o_status            = r_o_st;
    assign o_block_address     = r_o_blk;
    assign o_free_count        = r_o_free;
    assign o_used_count        = r_o_used;
    assign o_peak_usage        = r_o_peak;
    assign o_total_allocations = r_o_atot;
    assign o_total_frees       = r_o_ftot;
    assign o_pool_empty        = r_o_used == '0;
    assign o_pool_full         = r_o_free == '0;

endmodule

@@ rtl/fixed_block_pool_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// LIFO free-list allocator of equal blocks with an APB-style register port.
// ----------------------------------------------------------------------------
// One request at a time: start is taken when busy is low, and busy stays high
// until the single result has been shown for one cycle on o_valid, which the
// receiver cannot stall. An allocate reads the stack top and scales the index
// by the block size; a free that passes the null and range checks runs the
// one-bit-per-cycle alignment divider; rejected frees, allocates on an
// exhausted pool, clear and statistics reset go straight to the result. The
// next request may be accepted once busy has fallen after the result. Stack
// entries are tracked by a low-water mark, so reset and clear need no sweep
// of the stack memory.
module fixed_block_pool_allocator_top #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [31:0] o_block_address,
    output logic [10:0] o_free_count,
    output logic [10:0] o_used_count,
    output logic [10:0] o_peak_usage,
    output logic [31:0] o_total_allocations,
    output logic [31:0] o_total_frees,
    output logic        o_pool_empty,
    output logic        o_pool_full
);

    logic [fbpa_pkg::AW-1:0]  r_pool_base;
    logic [fbpa_pkg::BSW-1:0] r_block_size;
    logic [fbpa_pkg::CW-1:0]  r_pool_blocks;
    logic                     r_busy;
    logic                     accept, wr;
    logic [fbpa_pkg::BSW-1:0] bsize;
    logic [fbpa_pkg::CW-1:0]  nblocks;
    logic                     push, q_full, q_valid, pop;
    fbpa_pkg::t_cmd           f_cmd, q_cmd;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign accept  = start && !r_busy;
    assign busy    = r_busy;
    assign bsize   = fbpa_pkg::eff_size(r_block_size);
    assign nblocks = fbpa_pkg::eff_blocks(r_pool_blocks, 17'(MAX_BLOCKS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= fbpa_pkg::POOL_BASE_RST;
            r_block_size  <= fbpa_pkg::BLOCK_SIZE_RST;
            r_pool_blocks <= fbpa_pkg::POOL_BLOCKS_RST;
            r_busy        <= 1'b0;
        end else begin
            if (wr) begin
                case (paddr[3:2])
                    fbpa_pkg::REG_POOL_BASE:   r_pool_base   <= pwdata;
                    fbpa_pkg::REG_BLOCK_SIZE:  r_block_size  <= pwdata[fbpa_pkg::BSW-1:0];
                    fbpa_pkg::REG_POOL_BLOCKS: r_pool_blocks <= pwdata[fbpa_pkg::CW-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (o_valid) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        case (paddr[3:2])
            fbpa_pkg::REG_POOL_BASE:   prdata = r_pool_base;
            fbpa_pkg::REG_BLOCK_SIZE:  prdata = 32'(r_block_size);
            fbpa_pkg::REG_POOL_BLOCKS: prdata = 32'(r_pool_blocks);
            default:                   prdata = '0;
        endcase
    end

    fbpa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_op       (i_op),
        .i_address  (i_address),
        .i_pool_base(r_pool_base),
        .i_bsize    (bsize),
        .i_nblocks  (nblocks),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (f_cmd)
    );

    fbpa_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (f_cmd),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_full (q_full),
        .o_cmd  (q_cmd)
    );

    fbpa_back #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_cmd              (q_cmd),
        .o_pop              (pop),
        .i_pool_base        (r_pool_base),
        .i_bsize            (bsize),
        .i_nblocks          (nblocks),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_block_address    (o_block_address),
        .o_free_count       (o_free_count),
        .o_used_count       (o_used_count),
        .o_peak_usage       (o_peak_usage),
        .o_total_allocations(o_total_allocations),
        .o_total_frees      (o_total_frees),
        .o_pool_empty       (o_pool_empty),
        .o_pool_full        (o_pool_full)
    );

endmodule

@@ rtl/fbpa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_checker
// Port level checks of the block pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_top_assert.svh"

module fbpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [2:0]  o_status,
    input logic [31:0] o_block_address,
    input logic [10:0] o_free_count,
    input logic        o_pool_full
);

    `FBPA_AST_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")
    `FBPA_AST_SAME(a_result_busy, o_valid, busy, "result outside a transfer")
    `FBPA_AST_NEXT(a_one_result, o_valid, !o_valid, "repeated result")
    `FBPA_AST_SAME(a_full_flag, o_valid, o_pool_full == (o_free_count == 11'd0), "full flag")
    `FBPA_AST_SAME(a_addr_zero, o_valid && o_status != fbpa_pkg::ST_OK,
                   o_block_address == 32'd0, "address on failed request")

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);

@@ test/fixed_block_pool_allocator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_checker
// Watches the command, result and register ports of the block pool
// allocator. It keeps its own copy of the free list, counters and registers,
// works out the result of every accepted command and compares the result
// transfers field by field, in order.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_checker
    import fbpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        o_valid,
    input  logic [2:0]  o_status,
    input  logic [31:0] o_block_address,
    input  logic [10:0] o_free_count,
    input  logic [10:0] o_used_count,
    input  logic [10:0] o_peak_usage,
    input  logic [31:0] o_total_allocations,
    input  logic [31:0] o_total_frees,
    input  logic        o_pool_empty,
    input  logic        o_pool_full,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam int STACK_DEPTH = 1024;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] blk_addr;
        logic [10:0] free_cnt;
        logic [10:0] used_cnt;
        logic [10:0] peak;
        logic [31:0] allocs;
        logic [31:0] frees;
        logic        empty;
        logic        full;
    } t_pool_answer;

    logic [31:0] base_q;
    logic [16:0] bsize_q;
    logic [10:0] nblocks_q;
    logic [9:0]  free_list [STACK_DEPTH];
    logic [10:0] list_top;
    logic [10:0] peak_q;
    logic [31:0] alloc_sum;
    logic [31:0] free_sum;
    t_pool_answer awaited [$];
    int fails;
    int checked;

    assign o_fail_count = fails;
    assign o_pending    = awaited.size();
    assign o_checked    = checked;

    function automatic logic [10:0] live_blocks();
        if (nblocks_q == 0) return 11'd1;
        if (nblocks_q > STACK_DEPTH) return 11'(STACK_DEPTH);
        return nblocks_q;
    endfunction

    function automatic logic [10:0] in_use();
        logic [10:0] nb;
        nb = live_blocks();
        return (list_top >= nb) ? 11'd0 : nb - list_top;
    endfunction

    task automatic rebuild_list();
        logic [10:0] nb;
        nb = live_blocks();
        for (int i = 0; i < nb; i++) free_list[i] = 10'(nb - 1 - i);
        list_top = nb;
    endtask

    task automatic pool_to_reset();
        base_q    = POOL_BASE_RST;
        bsize_q   = BLOCK_SIZE_RST;
        nblocks_q = POOL_BLOCKS_RST;
        for (int i = 0; i < STACK_DEPTH; i++) free_list[i] = '0;
        rebuild_list();
        peak_q    = '0;
        alloc_sum = '0;
        free_sum  = '0;
    endtask

    task automatic apply_pool_op(input logic [1:0] op, input logic [31:0] addr,
                                 output t_pool_answer ans);
        logic [2:0]  st;
        logic [63:0] blk;
        logic [63:0] bs;
        logic [63:0] off;
        logic [10:0] nb;
        logic [9:0]  idx;
        st  = ST_OK;
        blk = '0;
        nb  = live_blocks();
        bs  = (bsize_q < 17'd8) ? 64'd8 : 64'(bsize_q);
        case (op)
            OP_ALLOC: begin
                if (list_top == 0) begin
                    st = ST_EXHAUSTED;
                end else begin
                    list_top  = list_top - 1;
                    idx       = free_list[list_top % STACK_DEPTH];
                    blk       = (64'(base_q) + 64'(idx) * bs) & 64'hFFFF_FFFF;
                    alloc_sum = alloc_sum + 1;
                    if (in_use() > peak_q) peak_q = in_use();
                end
            end
            OP_FREE: begin
                off = (64'(addr) - 64'(base_q)) & 64'hFFFF_FFFF;
                if (addr == 0) begin
                    st = ST_NULL;
                end else if (addr < base_q || off >= bs * 64'(nb) || (off % bs) != 0) begin
                    st = ST_NOT_POOL;
                end else if (list_top >= nb) begin
                    st = ST_OVERFREE;
                end else begin
                    free_list[list_top % STACK_DEPTH] = 10'(off / bs);
                    list_top = list_top + 1;
                    free_sum = free_sum + 1;
                end
            end
            OP_CLEAR: begin
                rebuild_list();
            end
            default: begin
                peak_q    = in_use();
                alloc_sum = '0;
                free_sum  = '0;
            end
        endcase
        ans.status   = st;
        ans.blk_addr = blk[31:0];
        ans.free_cnt = list_top;
        ans.used_cnt = in_use();
        ans.peak     = peak_q;
        ans.allocs   = alloc_sum;
        ans.frees    = free_sum;
        ans.empty    = (in_use() == 0);
        ans.full     = (list_top == 0);
    endtask

    task automatic compare_field(input string fname, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            fails++;
            if (fails <= 10)
                $display("%0t: mismatch on %s: expected 0x%08h, got 0x%08h",
                         $realtime, fname, exp_v, act_v);
        end
    endtask

    initial begin
        fails   = 0;
        checked = 0;
        pool_to_reset();
    end

    always @(posedge i_clk) begin
        t_pool_answer want;
        if (!i_rst_n) begin
            pool_to_reset();
            awaited.delete();
        end else begin
            if (o_valid) begin
                if (awaited.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result transfer with nothing outstanding", $realtime);
                end else begin
                    want = awaited.pop_front();
                    checked++;
                    compare_field("status", 32'(want.status), 32'(o_status));
                    compare_field("block_address", want.blk_addr, o_block_address);
                    compare_field("free_count", 32'(want.free_cnt), 32'(o_free_count));
                    compare_field("used_count", 32'(want.used_cnt), 32'(o_used_count));
                    compare_field("peak_usage", 32'(want.peak), 32'(o_peak_usage));
                    compare_field("total_allocations", want.allocs, o_total_allocations);
                    compare_field("total_frees", want.frees, o_total_frees);
                    compare_field("pool_empty", 32'(want.empty), 32'(o_pool_empty));
                    compare_field("pool_full", 32'(want.full), 32'(o_pool_full));
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_POOL_BASE:   base_q    = pwdata;
                    REG_BLOCK_SIZE:  bsize_q   = pwdata[16:0];
                    REG_POOL_BLOCKS: nblocks_q = pwdata[10:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                apply_pool_op(i_op, i_address, want);
                awaited.push_back(want);
            end
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the block pool allocator with directed and random command mixes
// over a range of pool base, block size and block count settings, with
// random gaps between commands; the checker beside the block compares
// every result and this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import fbpa_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [31:0] i_address;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [31:0] o_block_address;
    logic [10:0] o_free_count;
    logic [10:0] o_used_count;
    logic [10:0] o_peak_usage;
    logic [31:0] o_total_allocations;
    logic [31:0] o_total_frees;
    logic        o_pool_empty;
    logic        o_pool_full;
    int          fail_count;
    int          pending;
    int          checked;

    logic [31:0] cur_base;
    logic [16:0] cur_bsize;
    logic [10:0] cur_nblocks;
    int          cmds_sent;
    int          phases_run;
    bit          no_gaps;

    fixed_block_pool_allocator_top DUT (.*);

    fixed_block_pool_allocator_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_op, .i_address,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_valid, .o_status, .o_block_address, .o_free_count, .o_used_count,
        .o_peak_usage, .o_total_allocations, .o_total_frees,
        .o_pool_empty, .o_pool_full,
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        #10ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_POOL_BASE:   cur_base    = val;
            REG_BLOCK_SIZE:  cur_bsize   = val[16:0];
            REG_POOL_BLOCKS: cur_nblocks = val[10:0];
            default: ;
        endcase
    endtask

    task automatic send_cmd(input logic [1:0] op, input logic [31:0] addr);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        start     = 1'b1;
        i_op      = op;
        i_address = addr;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start     = 1'b0;
        i_address = $urandom;
        cmds_sent++;
    endtask

    function automatic logic [31:0] free_target();
        logic [31:0] bs;
        logic [31:0] nb;
        bs = (cur_bsize < 17'd8) ? 32'd8 : 32'(cur_bsize);
        nb = (cur_nblocks == 0) ? 32'd1 : (cur_nblocks > 1024 ? 32'd1024 : 32'(cur_nblocks));
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4, 5, 6: return cur_base + $urandom_range(0, nb - 1) * bs;
            7:       return cur_base + $urandom_range(0, nb - 1) * bs + $urandom_range(1, bs - 1);
            8:       return cur_base + nb * bs + $urandom_range(0, 3) * bs;
            9:       return cur_base - bs;
            10:      return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic settle();
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    initial begin
        logic [1:0] op;
        int n;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_op        = OP_ALLOC;
        i_address   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cur_base    = POOL_BASE_RST;
        cur_bsize   = BLOCK_SIZE_RST;
        cur_nblocks = POOL_BLOCKS_RST;
        cmds_sent   = 0;
        phases_run  = 0;
        no_gaps     = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset pool, checks on free, overfree, clear and stats
        send_cmd(OP_FREE, 32'd4096);
        send_cmd(OP_ALLOC, 32'd0);
        send_cmd(OP_ALLOC, 32'hFFFF_FFFF);
        send_cmd(OP_FREE, 32'd4104);
        send_cmd(OP_FREE, 32'd4104);
        send_cmd(OP_FREE, 32'd0);
        send_cmd(OP_FREE, 32'd4095);
        send_cmd(OP_FREE, 32'd4097);
        send_cmd(OP_FREE, 32'd4096 + 32'd8192);
        send_cmd(OP_FREE, 32'hFFFF_FFFF);
        send_cmd(OP_ALLOC, 32'd0);
        send_cmd(OP_STATS, 32'd0);
        send_cmd(OP_CLEAR, 32'd0);
        send_cmd(OP_ALLOC, 32'd0);
        settle();
        write_reg(REG_POOL_BLOCKS, 32'd2);
        write_reg(REG_BLOCK_SIZE, 32'd0);
        write_reg(REG_POOL_BASE, 32'hFFFF_FFF8);
        send_cmd(OP_ALLOC, 32'd0);
        send_cmd(OP_CLEAR, 32'd0);
        send_cmd(OP_ALLOC, 32'd0);
        send_cmd(OP_ALLOC, 32'd0);
        send_cmd(OP_ALLOC, 32'd0);
        send_cmd(OP_FREE, 32'd0);
        send_cmd(OP_FREE, 32'hFFFF_FFF8);
        send_cmd(OP_STATS, 32'd0);

        while (cmds_sent < 1250) begin
            settle();
            phases_run++;
            case ($urandom_range(0, 5))
                0: write_reg(REG_POOL_BASE, 32'd1);
                1: write_reg(REG_POOL_BASE, 32'hFFFF_FFFF);
                2: write_reg(REG_POOL_BASE, 32'hFFFF_0000);
                3: write_reg(REG_POOL_BASE, 32'd4096);
                default: write_reg(REG_POOL_BASE, $urandom);
            endcase
            case ($urandom_range(0, 6))
                0: write_reg(REG_BLOCK_SIZE, 32'd0);
                1: write_reg(REG_BLOCK_SIZE, $urandom_range(1, 8));
                2: write_reg(REG_BLOCK_SIZE, 32'd65536);
                3: write_reg(REG_BLOCK_SIZE, 32'h1_FFFF);
                4: write_reg(REG_BLOCK_SIZE, $urandom);
                default: write_reg(REG_BLOCK_SIZE, $urandom_range(8, 300));
            endcase
            case ($urandom_range(0, 7))
                0: write_reg(REG_POOL_BLOCKS, 32'd0);
                1: write_reg(REG_POOL_BLOCKS, 32'd1024);
                2: write_reg(REG_POOL_BLOCKS, 32'h7FF);
                3: write_reg(REG_POOL_BLOCKS, $urandom);
                default: write_reg(REG_POOL_BLOCKS, $urandom_range(1, 16));
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0) send_cmd(OP_CLEAR, $urandom);
            n = $urandom_range(60, 160);
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(0, 19))
                    0:       op = OP_CLEAR;
                    1:       op = OP_STATS;
                    2, 3, 4, 5, 6, 7, 8, 9, 10: op = OP_ALLOC;
                    default: op = OP_FREE;
                endcase
                send_cmd(op, (op == OP_FREE) ? free_target() : $urandom);
            end
        end
        settle();
        $display("%0d commands over %0d register settings, %0d results compared",
                 cmds_sent, phases_run + 2, checked);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_ram.sv
rtl/fbpa_front.sv
rtl/fbpa_queue.sv
rtl/fbpa_back.sv
rtl/fixed_block_pool_allocator_top.sv
rtl/fbpa_checker.sv
test/fixed_block_pool_allocator_checker.sv
test/testbench.sv
